// ===== rtl/core/srss_pkg.sv =====
// shared types and constants of the selective repeat send scheduler
// no dependencies; used by every module of the core
package srss_pkg;

    localparam int FS_W              = 21;    // file size register width
    localparam int SEQ_W             = 16;    // ack sequence number width
    localparam int ID_W              = 16;    // frame id width
    localparam int PAY_W             = 11;    // payload length field width
    localparam int RC_W              = 6;     // announce / end marker counter
    localparam int WORD_W            = 32;    // ack bitmap word width
    localparam int QUEUE_DEPTH       = 2;

    localparam int MAX_PACKETS_DEF   = 1024;
    localparam int PAYLOAD_BYTES_DEF = 1024;

    localparam int ANNOUNCE_REPEATS  = 50;
    localparam int END_REPEATS       = 3;
    localparam int CTRL_ID           = 7588;
    localparam int END_PAYLOAD       = 4;
    localparam int BIT_ONE           = 1;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_ACK    = 2'd1,
        ACT_NEXT   = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_ANNOUNCE = 3'd1,
        KIND_DATA     = 3'd2,
        KIND_END      = 3'd3,
        KIND_DONE     = 3'd4
    } frame_kind_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_ACK,
        OP_NEXT,
        OP_NOP
    } op_t;

    typedef struct packed {
        action_t            action;
        logic [SEQ_W-1:0]   ack_seq;
    } in_item_t;

    typedef struct packed {
        frame_kind_t        frame_kind;
        logic [ID_W-1:0]    frame_id;
        logic [PAY_W-1:0]   payload_bytes;
        logic               ack_rejected;
    } out_item_t;

    typedef struct packed {
        op_t                op;
        logic [SEQ_W-1:0]   seq;
    } cmd_t;

endpackage

// ===== rtl/core/srss_fifo.sv =====
// small first-in first-out queue of any packed item type
// depends on srss_pkg for the default depth
module srss_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = srss_pkg::QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output item_t rd_item,
    output logic  empty
);
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    item_t            slot [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = slot[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/core/srss_size.sv =====
// file size register and reciprocal divide giving packet count and tail length
// depends on srss_pkg
module srss_size #(
    parameter int MAX_PACKETS   = srss_pkg::MAX_PACKETS_DEF,
    parameter int PAYLOAD_BYTES = srss_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [srss_pkg::FS_W-1:0]           cfg_data,
    output logic                                busy,
    output logic [$clog2(MAX_PACKETS+1)-1:0]    pkt_count,
    output logic [srss_pkg::FS_W-1:0]           quot,
    output logic [$clog2(PAYLOAD_BYTES)-1:0]    last_rem
);
    import srss_pkg::*;

    localparam int NW    = $clog2(MAX_PACKETS + 1);
    localparam int RMW   = $clog2(PAYLOAD_BYTES);
    localparam int MAGIC = (1 << FS_W) / PAYLOAD_BYTES;
    localparam int MW    = $clog2(MAGIC + 1);
    localparam int PW    = FS_W + MW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_REM,
        S_FIX
    } state_t;

    state_t             state_reg;
    logic [FS_W-1:0]    fs_reg;
    logic [FS_W-1:0]    q_reg;
    logic [NW-1:0]      count_reg;
    logic [FS_W-1:0]    quot_reg;
    logic [RMW-1:0]     last_rem_reg;

    logic [PW-1:0]      prod;
    logic [FS_W-1:0]    q_est;
    logic [FS_W:0]      back_mul;
    logic [FS_W:0]      rem_wide;
    logic               rem_ge;
    logic [FS_W:0]      n_sum;
    logic [NW-1:0]      n_sat;

    // reciprocal estimate is at most one low, one compare and subtract fixes it
    always_comb
    begin
        prod     = PW'(fs_reg) * PW'(MAGIC);
        q_est    = FS_W'(prod >> FS_W);
        back_mul = (FS_W+1)'(q_reg) * (FS_W+1)'(PAYLOAD_BYTES);
        rem_wide = (FS_W+1)'(fs_reg) - back_mul;
        rem_ge   = (rem_wide >= (FS_W+1)'(PAYLOAD_BYTES));
        n_sum    = (FS_W+1)'(quot_reg) + (FS_W+1)'(last_rem_reg != '0);
        n_sat    = (n_sum > (FS_W+1)'(MAX_PACKETS)) ? NW'(MAX_PACKETS) : NW'(n_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fs_reg       <= '0;
            q_reg        <= '0;
            count_reg    <= '0;
            quot_reg     <= '0;
            last_rem_reg <= '0;
        end
        else if (cfg_we)
        begin
            state_reg <= S_MUL;
            fs_reg    <= cfg_data;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    state_reg <= S_IDLE;
                end
                S_MUL:
                begin
                    q_reg     <= q_est;
                    state_reg <= S_REM;
                end
                S_REM:
                begin
                    if (rem_ge)
                    begin
                        quot_reg     <= q_reg + FS_W'(1);
                        last_rem_reg <= RMW'(rem_wide - (FS_W+1)'(PAYLOAD_BYTES));
                    end
                    else
                    begin
                        quot_reg     <= q_reg;
                        last_rem_reg <= RMW'(rem_wide);
                    end
                    state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    count_reg <= n_sat;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign pkt_count = count_reg;
    assign quot      = quot_reg;
    assign last_rem  = last_rem_reg;

endmodule

// ===== rtl/core/srss_front.sv =====
// request intake: decodes the action code and queues commands for the scheduler
// depends on srss_pkg and srss_fifo
module srss_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srss_pkg::in_item_t  in_item,
    output logic                full,
    input  logic                cmd_pop,
    output srss_pkg::cmd_t      cmd,
    output logic                cmd_valid
);
    import srss_pkg::*;

    cmd_t decoded;
    logic cmd_empty;

    always_comb
    begin
        decoded.seq = in_item.ack_seq;
        unique case (in_item.action)
            ACT_START:  decoded.op = OP_START;
            ACT_ACK:    decoded.op = OP_ACK;
            ACT_NEXT:   decoded.op = OP_NEXT;
            ACT_UNUSED: decoded.op = OP_NOP;
            default:    decoded.op = OP_NOP;
        endcase
    end

    srss_fifo #(
        .item_t (cmd_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (decoded),
        .full    (full),
        .pop     (cmd_pop),
        .rd_item (cmd),
        .empty   (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

// ===== rtl/core/srss_back.sv =====
// scheduler engine: phase sequencing, ack bitmap memory and word-wise resend scan
// depends on srss_pkg; fed by srss_front and srss_size
module srss_back #(
    parameter int MAX_PACKETS   = srss_pkg::MAX_PACKETS_DEF,
    parameter int PAYLOAD_BYTES = srss_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srss_pkg::cmd_t                      cmd,
    input  logic                                cmd_valid,
    output logic                                cmd_pop,
    input  logic                                size_busy,
    input  logic [$clog2(MAX_PACKETS+1)-1:0]    pkt_count,
    input  logic [srss_pkg::FS_W-1:0]           quot,
    input  logic [$clog2(PAYLOAD_BYTES)-1:0]    last_rem,
    input  logic                                res_full,
    output logic                                res_push,
    output srss_pkg::out_item_t                 res_item
);
    import srss_pkg::*;

    localparam int NW   = $clog2(MAX_PACKETS + 1);
    localparam int ROWS = (MAX_PACKETS + WORD_W - 1) / WORD_W;
    localparam int RIW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BW   = $clog2(WORD_W);
    localparam int CW   = RIW + BW;
    localparam int XW   = (CW + 1 > NW) ? CW + 1 : NW;
    localparam int RMW  = $clog2(PAYLOAD_BYTES);
    localparam int PAYW = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [PAYW-1:0] PB_FULL = PAYW'(PAYLOAD_BYTES);

    typedef enum logic [2:0] {
        PH_ANNOUNCE,
        PH_BLAST,
        PH_REPEAT,
        PH_END,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK_RD,
        ST_ACK_WR,
        ST_SRCH_RD,
        ST_SRCH_EV
    } state_t;

    state_t             state_reg,  state_next;
    phase_t             phase_reg,  phase_next;
    logic [NW-1:0]      scan_reg,   scan_next;
    logic [RC_W-1:0]    rc_reg,     rc_next;
    logic               resent_reg, resent_next;
    logic [RIW-1:0]     row_reg,    row_next;
    logic [BW-1:0]      low_reg,    low_next;
    logic [BW-1:0]      bit_reg,    bit_next;
    logic [ROWS-1:0]    valid_reg,  valid_next;

    logic [WORD_W-1:0]  mem [ROWS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [WORD_W-1:0]  mem_wdata;

    logic [WORD_W-1:0]  word_eff;
    logic [WORD_W-1:0]  low_mask;
    logic [WORD_W-1:0]  word_masked;
    logic               hit;
    logic [BW-1:0]      hit_pos;
    logic [CW-1:0]      cand;
    logic               cand_ok;
    logic [CW:0]        next_start;
    logic               more_rows;

    function automatic logic [PAY_W-1:0] pay_of(
        input logic [NW-1:0]    idx,
        input logic [FS_W-1:0]  q,
        input logic [RMW-1:0]   r
    );
        logic [PAY_W-1:0] len;
        if (FS_W'(idx) < q)
        begin
            len = PAY_W'(PB_FULL);
        end
        else
        begin
            len = PAY_W'(r);
        end
        return len;
    endfunction

    // word scan: rows never written read as all unacked
    always_comb
    begin
        word_eff    = valid_reg[row_reg] ? rd_data_reg : '0;
        low_mask    = (WORD_W'(BIT_ONE) << low_reg) - WORD_W'(BIT_ONE);
        word_masked = word_eff | low_mask;
        hit         = 1'b0;
        hit_pos     = '0;
        for (int k = WORD_W - 1; k >= 0; k--)
        begin
            if (!word_masked[k])
            begin
                hit     = 1'b1;
                hit_pos = BW'(k);
            end
        end
        cand       = {row_reg, hit_pos};
        cand_ok    = hit && (XW'(cand) < XW'(pkt_count));
        next_start = {(RIW+1)'(row_reg) + (RIW+1)'(1), BW'(0)};
        more_rows  = !hit && (XW'(next_start) < XW'(pkt_count));
    end

    always_comb
    begin
        logic              srch_go;
        logic              fail;
        logic              end_go;
        logic              resent_was;
        logic [NW-1:0]     srch_from;
        logic [RC_W-1:0]   rc_inc;
        phase_t            ph;

        state_next  = state_reg;
        phase_next  = phase_reg;
        scan_next   = scan_reg;
        rc_next     = rc_reg;
        resent_next = resent_reg;
        row_next    = row_reg;
        low_next    = low_reg;
        bit_next    = bit_reg;
        valid_next  = valid_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res_item    = '0;
        mem_we      = 1'b0;
        mem_wdata   = word_eff | (WORD_W'(BIT_ONE) << bit_reg);
        srch_go     = 1'b0;
        fail        = 1'b0;
        end_go      = 1'b0;
        resent_was  = 1'b0;
        srch_from   = '0;
        rc_inc      = '0;
        ph          = phase_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !size_busy && !res_full)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_START:
                        begin
                            valid_next  = '0;
                            scan_next   = '0;
                            phase_next  = PH_ANNOUNCE;
                            rc_next     = '0;
                            resent_next = 1'b0;
                            res_push    = 1'b1;
                        end
                        OP_ACK:
                        begin
                            if (cmd.seq < SEQ_W'(pkt_count))
                            begin
                                row_next   = RIW'(cmd.seq >> BW);
                                bit_next   = cmd.seq[BW-1:0];
                                state_next = ST_ACK_RD;
                            end
                            else
                            begin
                                res_push              = 1'b1;
                                res_item.ack_rejected = 1'b1;
                            end
                        end
                        OP_NEXT:
                        begin
                            // empty file skips straight to the end markers
                            if (phase_reg == PH_ANNOUNCE && pkt_count == '0)
                            begin
                                ph         = PH_END;
                                phase_next = PH_END;
                                rc_next    = '0;
                            end
                            unique case (ph)
                                PH_ANNOUNCE:
                                begin
                                    res_push            = 1'b1;
                                    res_item.frame_kind = KIND_ANNOUNCE;
                                    res_item.frame_id   = ID_W'(CTRL_ID);
                                    rc_inc              = rc_reg + RC_W'(1);
                                    if (rc_inc >= RC_W'(ANNOUNCE_REPEATS))
                                    begin
                                        phase_next = PH_BLAST;
                                        rc_next    = '0;
                                        scan_next  = '0;
                                    end
                                    else
                                    begin
                                        rc_next = rc_inc;
                                    end
                                end
                                PH_BLAST:
                                begin
                                    if (scan_reg >= pkt_count)
                                    begin
                                        phase_next  = PH_REPEAT;
                                        scan_next   = '0;
                                        resent_next = 1'b0;
                                        srch_go     = 1'b1;
                                        srch_from   = '0;
                                    end
                                    else
                                    begin
                                        res_push               = 1'b1;
                                        res_item.frame_kind    = KIND_DATA;
                                        res_item.frame_id      = ID_W'(scan_reg);
                                        res_item.payload_bytes = pay_of(scan_reg, quot, last_rem);
                                        scan_next              = scan_reg + NW'(1);
                                        if (scan_next >= pkt_count)
                                        begin
                                            phase_next  = PH_REPEAT;
                                            scan_next   = '0;
                                            resent_next = 1'b0;
                                        end
                                    end
                                end
                                PH_REPEAT:
                                begin
                                    srch_go   = 1'b1;
                                    srch_from = scan_reg;
                                end
                                PH_END:
                                begin
                                    end_go = 1'b1;
                                end
                                PH_DONE:
                                begin
                                    res_push            = 1'b1;
                                    res_item.frame_kind = KIND_DONE;
                                end
                                default:
                                begin
                                    res_push = 1'b1;
                                end
                            endcase
                        end
                        OP_NOP:
                        begin
                            res_push = 1'b1;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_ACK_RD:
            begin
                state_next = ST_ACK_WR;
            end
            ST_ACK_WR:
            begin
                mem_we              = 1'b1;
                valid_next[row_reg] = 1'b1;
                res_push            = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_EV;
            end
            ST_SRCH_EV:
            begin
                if (cand_ok)
                begin
                    res_push               = 1'b1;
                    res_item.frame_kind    = KIND_DATA;
                    res_item.frame_id      = ID_W'(cand);
                    res_item.payload_bytes = pay_of(NW'(cand), quot, last_rem);
                    scan_next              = NW'(cand) + NW'(1);
                    resent_next            = 1'b1;
                    state_next             = ST_IDLE;
                end
                else if (more_rows)
                begin
                    row_next   = row_reg + RIW'(1);
                    low_next   = '0;
                    state_next = ST_SRCH_RD;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // start a scan at a packet index
        if (srch_go)
        begin
            if (srch_from >= pkt_count)
            begin
                fail = 1'b1;
            end
            else
            begin
                row_next   = RIW'(srch_from >> BW);
                low_next   = BW'(srch_from);
                state_next = ST_SRCH_RD;
            end
        end

        // nothing left from the scan point: rescan once if this pass resent anything
        if (fail)
        begin
            resent_was  = resent_next;
            resent_next = 1'b0;
            scan_next   = '0;
            if (resent_was && pkt_count != '0)
            begin
                row_next   = '0;
                low_next   = '0;
                state_next = ST_SRCH_RD;
            end
            else
            begin
                phase_next = PH_END;
                rc_next    = '0;
                end_go     = 1'b1;
            end
        end

        if (end_go)
        begin
            res_push               = 1'b1;
            res_item.frame_kind    = KIND_END;
            res_item.frame_id      = ID_W'(CTRL_ID);
            res_item.payload_bytes = PAY_W'(END_PAYLOAD);
            state_next             = ST_IDLE;
            rc_inc                 = rc_next + RC_W'(1);
            if (rc_inc >= RC_W'(END_REPEATS))
            begin
                phase_next = PH_DONE;
                rc_next    = '0;
            end
            else
            begin
                phase_next = PH_END;
                rc_next    = rc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_ANNOUNCE;
            scan_reg   <= '0;
            rc_reg     <= '0;
            resent_reg <= 1'b0;
            row_reg    <= '0;
            low_reg    <= '0;
            bit_reg    <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            scan_reg   <= scan_next;
            rc_reg     <= rc_next;
            resent_reg <= resent_next;
            row_reg    <= row_next;
            low_reg    <= low_next;
            bit_reg    <= bit_next;
            valid_reg  <= valid_next;
        end
    end

    // ack bitmap words, registered read at the current row
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[row_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[row_reg];
    end

endmodule

// ===== rtl/core/selective_repeat_send_scheduler_core.sv =====
// selective repeat send scheduler, top level; depends on srss_pkg and all srss_* modules
// path: command queue, engine, result queue; start, unused code, rejected ack, announce,
// blast, end, finished go from idle; a good ack reads then writes its bitmap word; a resend
// scan checks 32-bit bitmap words in turn (two scans of ceil(MAX_PACKETS/32) words at most)
// in: 1 request per cycle unless full; a good ack or scan holds later requests in the queue
// reset: all control cleared, file size 0; a size write stalls requests during the divide
module selective_repeat_send_scheduler_core #(
    parameter int MAX_PACKETS   = srss_pkg::MAX_PACKETS_DEF,
    parameter int PAYLOAD_BYTES = srss_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [srss_pkg::FS_W-1:0]   cfg_data,
    input  logic                        push,
    input  srss_pkg::in_item_t          in_item,
    output logic                        full,
    input  logic                        pop,
    output srss_pkg::out_item_t         out_item,
    output logic                        empty
);
    import srss_pkg::*;

    localparam int NW  = $clog2(MAX_PACKETS + 1);
    localparam int RMW = $clog2(PAYLOAD_BYTES);

    // front to back command request
    cmd_t               cmd;
    logic               cmd_valid;
    logic               cmd_pop;

    // size divider outputs
    logic               size_busy;
    logic [NW-1:0]      pkt_count;
    logic [FS_W-1:0]    quot;
    logic [RMW-1:0]     last_rem;

    // back to result queue
    logic               res_push;
    logic               res_full;
    out_item_t          res_item;

    // file size register plus reciprocal divide for packet count and short tail
    srss_size #(
        .MAX_PACKETS   (MAX_PACKETS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_size (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .busy      (size_busy),
        .pkt_count (pkt_count),
        .quot      (quot),
        .last_rem  (last_rem)
    );

    // intake: decode and buffer requests
    srss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_valid (cmd_valid)
    );

    // scheduler engine with the ack bitmap
    srss_back #(
        .MAX_PACKETS   (MAX_PACKETS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .size_busy (size_busy),
        .pkt_count (pkt_count),
        .quot      (quot),
        .last_rem  (last_rem),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    // result queue decouples the engine from the consumer
    srss_fifo #(
        .item_t (out_item_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_item (res_item),
        .full    (res_full),
        .pop     (pop),
        .rd_item (out_item),
        .empty   (empty)
    );

endmodule
